>>> hw/rtl/text_vram_dirty_tracker_with_key_latch_core_assert.svh
// Assertion helpers used by the checker of this block.
`ifndef TEXT_VRAM_DIRTY_TRACKER_WITH_KEY_LATCH_CORE_ASSERT_SVH
`define TEXT_VRAM_DIRTY_TRACKER_WITH_KEY_LATCH_CORE_ASSERT_SVH

// Same-cycle implication, off during reset.
`define TVDT_ASSERT_IMP(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off during reset.
`define TVDT_ASSERT_NXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also holds across reset.
`define TVDT_ASSERT_NXT_ALWAYS(label, clk, ante, cons, msg) \
  label: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hw/rtl/tvdt_pkg.sv
package tvdt_pkg;

  localparam int VRAM_BYTES_DEF = 128;
  localparam int CHAR_W = 8;

  localparam logic [1:0] OP_WRITE    = 2'd0;
  localparam logic [1:0] OP_END      = 2'd1;
  localparam logic [1:0] OP_KEY      = 2'd2;
  localparam logic [1:0] OP_READ_KEY = 2'd3;

  localparam logic [1:0] KIND_ACK  = 2'd0;
  localparam logic [1:0] KIND_CELL = 2'd1;
  localparam logic [1:0] KIND_NONE = 2'd2;
  localparam logic [1:0] KIND_KEY  = 2'd3;

  localparam logic [7:0] SPACE_CHAR     = 8'h20;
  localparam logic [7:0] KEY_FLAG       = 8'h80;
  localparam logic [7:0] BS_ASCII       = 8'd8;
  localparam logic [7:0] BS_CODE_RESET  = 8'd127;

  typedef struct packed {
    logic [1:0] opcode;
    logic [7:0] vram_address;
    logic [7:0] char_value;
    logic [7:0] key_code;
  } in_item_t;

  typedef struct packed {
    logic [1:0] result_kind;
    logic [2:0] cell_column;
    logic [5:0] cell_row_pixel;
    logic [7:0] left_char;
    logic [7:0] right_char;
    logic [7:0] key_value;
    logic       last;
  } out_item_t;

endpackage

>>> hw/rtl/text_vram_dirty_tracker_with_key_latch_core.sv
// Text video memory of VRAM_BYTES bytes (a power of two) held as VRAM_BYTES/2 two-character
// cells in one memory, each row carrying its dirty mark, plus a one-key latch. After reset
// a clearing pass fills every cell with spaces and clears its dirty mark while input is
// stalled. One item is worked at a time: a key arrival, a key read or an end of frame with
// nothing to repaint passes through ST_RESP, which loads the output register once it is
// free; a video write first passes through ST_WR_CMP, because the cell is read from the
// memory, compared and written back only if it changed. An end of frame with pending
// repaint walks the cells, reading each in ST_SCAN_RD and checking it in ST_SCAN_CHK, up
// to the last dirty one, each reported cell waiting for the output register to be free.
// The output register lets the next item be accepted while a result is still waiting to be
// taken.
module text_vram_dirty_tracker_with_key_latch_core
  import tvdt_pkg::*;
#(
  parameter int VRAM_BYTES = VRAM_BYTES_DEF
) (
  input  logic       clk,
  input  logic       rst,
  input  in_item_t   in_data,
  input  logic       in_valid,
  output logic       in_stall,
  output out_item_t  out_data,
  output logic       out_valid,
  input  logic       out_stall,
  input  logic       cfg_valid,
  output logic       cfg_ready,
  input  logic [7:0] cfg_data
);

  localparam int CELLS = VRAM_BYTES / 2;
  localparam int AW    = $clog2(VRAM_BYTES);
  localparam int CW    = AW - 1;
  localparam int NW    = $clog2(CELLS + 1);
  localparam int RW    = 2 * CHAR_W + 1;

  typedef enum logic [5:0] {
    ST_CLEAR    = 6'b000001,
    ST_IDLE     = 6'b000010,
    ST_WR_CMP   = 6'b000100,
    ST_RESP     = 6'b001000,
    ST_SCAN_RD  = 6'b010000,
    ST_SCAN_CHK = 6'b100000
  } state_t;

  state_t          state;
  logic [CW-1:0]   idx;
  logic [NW-1:0]   dirty_count;
  logic [7:0]      latched_key;
  logic [7:0]      backspace_code;
  out_item_t       resp;
  out_item_t       resp_next;
  logic [CW-1:0]   wr_cell;
  logic            wr_hi;
  logic [7:0]      wr_char;

  // row layout: {dirty, right char, left char}
  logic [RW-1:0]   mem [CELLS];
  logic [RW-1:0]   rdata;
  logic [CW-1:0]   rd_addr;
  logic            we;
  logic [CW-1:0]   waddr;
  logic [RW-1:0]   wdata;

  logic            accept;
  logic            out_free;
  logic            out_load;
  logic [AW+7:0]   addr_w;
  logic [7:0]      old_char;
  logic            changed;
  logic [RW-1:0]   merged;
  logic [7:0]      key_f;
  logic [CW+5:0]   idx_w;

  assign cfg_ready = 1'b1;
  assign in_stall  = (state != ST_IDLE);
  assign accept    = in_valid && !in_stall;
  assign out_free  = !out_valid || !out_stall;
  assign out_load  = out_free &&
                     ((state == ST_RESP) || ((state == ST_SCAN_CHK) && rdata[RW-1]));
  assign addr_w    = (AW + 8)'(in_data.vram_address);
  assign idx_w     = (CW + 6)'(idx);

  always_comb begin
    old_char = wr_hi ? rdata[15:8] : rdata[7:0];
    changed  = (old_char != wr_char);
    merged   = wr_hi ? {1'b1, wr_char, rdata[7:0]} : {1'b1, rdata[15:8], wr_char};
  end

  always_comb begin
    key_f = in_data.key_code[7] ? 8'h00 : in_data.key_code;
    if (key_f == backspace_code) begin
      key_f = BS_ASCII;
    end
  end

  always_comb begin
    resp_next      = '0;
    resp_next.last = 1'b1;
    case (in_data.opcode)
      OP_END: begin
        resp_next.result_kind = KIND_NONE;
      end
      OP_READ_KEY: begin
        resp_next.result_kind = KIND_KEY;
        resp_next.key_value   = (latched_key != '0) ? (latched_key | KEY_FLAG) : 8'h00;
      end
      default: begin
        resp_next.result_kind = KIND_ACK;
      end
    endcase
  end

  always_comb begin
    rd_addr = (state == ST_IDLE) ? addr_w[AW-1:1] : idx;
    we      = 1'b0;
    waddr   = idx;
    wdata   = {1'b0, rdata[15:0]};
    case (state)
      ST_CLEAR: begin
        we    = 1'b1;
        wdata = {1'b0, SPACE_CHAR, SPACE_CHAR};
      end
      ST_WR_CMP: begin
        we    = changed;
        waddr = wr_cell;
        wdata = merged;
      end
      ST_SCAN_CHK: begin
        we = rdata[RW-1] && out_free;
      end
      default: begin
        we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_CLEAR;
      idx            <= '0;
      dirty_count    <= '0;
      latched_key    <= '0;
      backspace_code <= BS_CODE_RESET;
      out_valid      <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        backspace_code <= cfg_data;
      end
      out_valid <= out_load || (out_valid && out_stall);
      case (state)
        ST_CLEAR: begin
          idx <= idx + CW'(1);
          if (idx == CW'(CELLS - 1)) begin
            state <= ST_IDLE;
          end
        end
        ST_IDLE: begin
          if (accept) begin
            resp <= resp_next;
            case (in_data.opcode)
              OP_WRITE: begin
                wr_cell <= addr_w[AW-1:1];
                wr_hi   <= addr_w[0];
                wr_char <= in_data.char_value;
                state   <= ST_WR_CMP;
              end
              OP_END: begin
                if (dirty_count == '0) begin
                  state <= ST_RESP;
                end else begin
                  idx   <= '0;
                  state <= ST_SCAN_RD;
                end
              end
              OP_KEY: begin
                latched_key <= key_f;
                state       <= ST_RESP;
              end
              default: begin
                latched_key <= '0;
                state       <= ST_RESP;
              end
            endcase
          end
        end
        ST_WR_CMP: begin
          // a clean cell turning dirty adds one to the repaint count
          if (changed && !rdata[RW-1]) begin
            dirty_count <= dirty_count + NW'(1);
          end
          state <= ST_RESP;
        end
        ST_RESP: begin
          if (out_free) begin
            out_data <= resp;
            state    <= ST_IDLE;
          end
        end
        ST_SCAN_RD: begin
          state <= ST_SCAN_CHK;
        end
        ST_SCAN_CHK: begin
          if (!rdata[RW-1]) begin
            idx   <= idx + CW'(1);
            state <= ST_SCAN_RD;
          end else if (out_free) begin
            out_data.result_kind     <= KIND_CELL;
            out_data.cell_column     <= idx[2:0];
            out_data.cell_row_pixel  <= {idx_w[5:3], 3'b000};
            out_data.left_char       <= rdata[7:0];
            out_data.right_char      <= rdata[15:8];
            out_data.key_value       <= '0;
            out_data.last            <= (dirty_count == NW'(1));
            dirty_count              <= dirty_count - NW'(1);
            // stop at the last dirty cell
            if (dirty_count == NW'(1)) begin
              state <= ST_IDLE;
            end else begin
              idx   <= idx + CW'(1);
              state <= ST_SCAN_RD;
            end
          end
        end
        default: begin
          state <= ST_IDLE;
        end
      endcase
    end
  end

endmodule

>>> hw/rtl/tvdt_checker.sv
`include "text_vram_dirty_tracker_with_key_latch_core_assert.svh"

module tvdt_checker
  import tvdt_pkg::*;
(
  input logic      clk,
  input logic      rst,
  input logic      in_valid,
  input logic      in_stall,
  input out_item_t out_data,
  input logic      out_valid,
  input logic      out_stall
);

  `TVDT_ASSERT_NXT_ALWAYS(a_reset_stalls_input, clk, rst, in_stall && !out_valid, "input not stalled after reset")
  `TVDT_ASSERT_NXT(a_one_item_at_a_time, clk, rst, in_valid && !in_stall, in_stall, "input taken while an item is at work")
  `TVDT_ASSERT_NXT(a_out_hold, clk, rst, out_valid && out_stall, out_valid && $stable(out_data), "stalled result changed")
  `TVDT_ASSERT_IMP(a_single_results_last, clk, rst, out_valid && (out_data.result_kind != KIND_CELL), out_data.last, "single result without last")

endmodule

bind text_vram_dirty_tracker_with_key_latch_core tvdt_checker u_tvdt_checker (.*);

>>> dv/tb_text_vram_dirty_tracker_with_key_latch_core.sv
module tb_text_vram_dirty_tracker_with_key_latch_core;
  import tvdt_pkg::*;

  localparam int VRAM_BYTES = VRAM_BYTES_DEF;
  localparam int CELLS = VRAM_BYTES / 2;
  localparam int IDLE_LIMIT = 3000;
  localparam int PRESSURE_AT = 200;
  localparam int PRESSURE_LEN = 250;

  logic      clk = 1'b0;
  logic      rst = 1'b1;
  in_item_t  in_data = '0;
  logic      in_valid = 1'b0;
  logic      in_stall;
  out_item_t out_data;
  logic      out_valid;
  logic      out_stall = 1'b0;
  logic      cfg_valid = 1'b0;
  logic      cfg_ready;
  logic [7:0] cfg_data = 8'h00;

  text_vram_dirty_tracker_with_key_latch_core i_dut (
    .clk       (clk),
    .rst       (rst),
    .in_data   (in_data),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_data  (out_data),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .cfg_data  (cfg_data)
  );

  always #5 clk = ~clk;

  // screen and keyboard state as the block should hold it
  logic [7:0] screen_bytes [VRAM_BYTES];
  bit         cell_dirty [CELLS];
  bit         repaint_flag;
  logic [7:0] key_latch;
  logic [7:0] bs_code;

  in_item_t  bus_items [$];
  out_item_t replies_due [$];

  int unsigned fail_cnt = 0;
  int unsigned n_results = 0;
  int unsigned idle_cycles = 0;
  bit          calm = 1'b0;
  bit          pressure_done = 1'b0;
  int unsigned send_gap;
  int unsigned recv_hold;

  function automatic int unsigned gap_len();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 55) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 12);
    return $urandom_range(20, 60);
  endfunction

  // Work out every reply one bus item causes and update the screen state.
  task automatic apply_to_screen(input in_item_t it);
    out_item_t r;
    out_item_t prev;
    bit        have_prev;
    int        a;
    logic [7:0] k;
    r = '0;
    r.last = 1'b1;
    have_prev = 1'b0;
    prev = '0;
    case (it.opcode)
      OP_WRITE: begin
        a = it.vram_address % VRAM_BYTES;
        if (screen_bytes[a] != it.char_value) begin
          screen_bytes[a] = it.char_value;
          cell_dirty[a / 2] = 1'b1;
          repaint_flag = 1'b1;
        end
        r.result_kind = KIND_ACK;
        replies_due.push_back(r);
      end
      OP_END: begin
        if (repaint_flag) begin
          repaint_flag = 1'b0;
          for (int n = 0; n < CELLS; n++) begin
            if (cell_dirty[n]) begin
              cell_dirty[n] = 1'b0;
              // hold each cell back until we know whether it is the final one
              if (have_prev) replies_due.push_back(prev);
              prev = '0;
              prev.result_kind = KIND_CELL;
              prev.cell_column = 3'(n % 8);
              prev.cell_row_pixel = 6'((n / 8) * 8);
              prev.left_char = screen_bytes[2 * n];
              prev.right_char = screen_bytes[2 * n + 1];
              have_prev = 1'b1;
            end
          end
        end
        if (have_prev) begin
          prev.last = 1'b1;
          replies_due.push_back(prev);
        end else begin
          r.result_kind = KIND_NONE;
          replies_due.push_back(r);
        end
      end
      OP_KEY: begin
        k = it.key_code;
        if (k >= KEY_FLAG) k = 8'h00;
        if (k == bs_code) k = BS_ASCII;
        key_latch = k;
        r.result_kind = KIND_ACK;
        replies_due.push_back(r);
      end
      default: begin
        r.result_kind = KIND_KEY;
        if (key_latch != 8'h00) begin
          r.key_value = key_latch | KEY_FLAG;
          key_latch = 8'h00;
        end
        replies_due.push_back(r);
      end
    endcase
  endtask

  task automatic check_field(input string name, input logic [7:0] want, input logic [7:0] got);
    if (got !== want) begin
      $error("%s: expected %0h, got %0h", name, want, got);
      fail_cnt++;
    end
  endtask

  task automatic check_reply(input out_item_t got);
    out_item_t want;
    n_results++;
    if (replies_due.size() == 0) begin
      $error("result with no item pending: %0h", got);
      fail_cnt++;
    end else begin
      want = replies_due.pop_front();
      check_field("result_kind", 8'(want.result_kind), 8'(got.result_kind));
      check_field("cell_column", 8'(want.cell_column), 8'(got.cell_column));
      check_field("cell_row_pixel", 8'(want.cell_row_pixel), 8'(got.cell_row_pixel));
      check_field("left_char", want.left_char, got.left_char);
      check_field("right_char", want.right_char, got.right_char);
      check_field("key_value", want.key_value, got.key_value);
      check_field("last", 8'(want.last), 8'(got.last));
    end
  endtask

  // driver: offer bus items, hold while stalled, idle at random after each item
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
      send_gap = 0;
    end else begin
      if (in_valid && !in_stall) begin
        apply_to_screen(in_data);
        send_gap = calm ? 0 : gap_len();
      end
      if (in_valid && in_stall) begin
        // hold the offered item
      end else if (send_gap > 0) begin
        in_valid <= 1'b0;
        send_gap--;
      end else if (bus_items.size() > 0) begin
        in_data <= bus_items.pop_front();
        in_valid <= 1'b1;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // monitor: take replies, stall at random, and once hold off long enough to back up the block
  always @(posedge clk) begin
    if (rst) begin
      out_stall <= 1'b0;
      recv_hold = 0;
    end else begin
      if (out_valid && !out_stall) check_reply(out_data);
      if (recv_hold > 0) begin
        out_stall <= 1'b1;
        recv_hold--;
      end else if (!pressure_done && n_results >= PRESSURE_AT) begin
        pressure_done = 1'b1;
        recv_hold = PRESSURE_LEN - 1;
        out_stall <= 1'b1;
      end else if (!calm && $urandom_range(0, 3) == 0) begin
        recv_hold = gap_len();
        out_stall <= 1'b1;
      end else begin
        out_stall <= 1'b0;
      end
    end
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready))
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
  end

  initial begin
    while (idle_cycles < IDLE_LIMIT) @(posedge clk);
    $display("CHECK FAILED");
    $finish;
  end

  task automatic queue_item(input logic [1:0] op, input logic [7:0] addr,
                            input logic [7:0] ch, input logic [7:0] key);
    in_item_t it;
    it.opcode = op;
    it.vram_address = addr;
    it.char_value = ch;
    it.key_code = key;
    bus_items.push_back(it);
  endtask

  task automatic wait_drained();
    do @(posedge clk); while (bus_items.size() != 0 || in_valid || replies_due.size() != 0);
    repeat (4) @(posedge clk);
  endtask

  task automatic write_backspace(input logic [7:0] v);
    @(posedge clk);
    cfg_valid <= 1'b1;
    cfg_data <= v;
    do @(posedge clk); while (!cfg_ready);
    bs_code = v;
    cfg_valid <= 1'b0;
  endtask

  function automatic logic [7:0] pick_key();
    case ($urandom_range(0, 4))
      0: return bs_code;
      1: return 8'h80 | 8'($urandom_range(0, 127));
      2: return 8'h00;
      default: return 8'($urandom);
    endcase
  endfunction

  // Mostly write bursts closed by an end of frame, key arrive/read pairs, some noise.
  task automatic queue_random(input int count);
    int made;
    int kind;
    int len;
    logic [7:0] base;
    logic [7:0] addr;
    logic [7:0] ch;
    made = 0;
    while (made < count) begin
      kind = $urandom_range(0, 9);
      if (kind < 5) begin
        len = $urandom_range(1, 8);
        base = 8'($urandom);
        for (int j = 0; j < len; j++) begin
          // nearby bytes rewrite both halves of a cell
          addr = $urandom_range(0, 1) ? 8'(base + $urandom_range(0, 3)) : 8'($urandom);
          ch = ($urandom_range(0, 3) == 0) ? SPACE_CHAR : 8'($urandom);
          queue_item(OP_WRITE, addr, ch, 8'($urandom));
        end
        queue_item(OP_END, 8'($urandom), 8'($urandom), 8'($urandom));
        made += len + 1;
      end else if (kind < 7) begin
        queue_item(OP_KEY, 8'($urandom), 8'($urandom), pick_key());
        made++;
        if ($urandom_range(0, 3) == 0) begin
          queue_item(OP_KEY, 8'($urandom), 8'($urandom), pick_key());
          made++;
        end
        queue_item(OP_READ_KEY, 8'($urandom), 8'($urandom), 8'($urandom));
        made++;
        if ($urandom_range(0, 3) == 0) begin
          queue_item(OP_READ_KEY, 8'($urandom), 8'($urandom), 8'($urandom));
          made++;
        end
      end else begin
        len = $urandom_range(1, 3);
        for (int j = 0; j < len; j++)
          queue_item(2'($urandom), 8'($urandom), 8'($urandom), 8'($urandom));
        made += len;
      end
    end
  endtask

  initial begin
    for (int i = 0; i < VRAM_BYTES; i++) screen_bytes[i] = SPACE_CHAR;
    for (int i = 0; i < CELLS; i++) cell_dirty[i] = 1'b0;
    repaint_flag = 1'b0;
    key_latch = 8'h00;
    bs_code = BS_CODE_RESET;

    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // empty latch, nothing to repaint, unchanged write
    queue_item(OP_READ_KEY, 8'h00, 8'h00, 8'h00);
    queue_item(OP_END, 8'h00, 8'h00, 8'h00);
    queue_item(OP_WRITE, 8'h05, SPACE_CHAR, 8'hFF);
    queue_item(OP_END, 8'hFF, 8'hFF, 8'hFF);
    // address wrap onto the first and last cells
    queue_item(OP_WRITE, 8'h00, 8'h41, 8'h00);
    queue_item(OP_WRITE, 8'h80, 8'hFF, 8'h00);
    queue_item(OP_WRITE, 8'h01, 8'h00, 8'h00);
    queue_item(OP_WRITE, 8'hFF, 8'h7E, 8'h00);
    queue_item(OP_WRITE, 8'h7E, SPACE_CHAR, 8'h00);
    queue_item(OP_END, 8'h00, 8'h00, 8'h00);
    queue_item(OP_END, 8'h00, 8'h00, 8'h00);
    // key filtering: plain, high code dropped, backspace, zero means empty, overwrite
    queue_item(OP_KEY, 8'h00, 8'h00, 8'h41);
    queue_item(OP_READ_KEY, 8'h00, 8'h00, 8'h00);
    queue_item(OP_KEY, 8'h00, 8'h00, 8'h80);
    queue_item(OP_READ_KEY, 8'h00, 8'h00, 8'h00);
    queue_item(OP_KEY, 8'h00, 8'h00, 8'h7F);
    queue_item(OP_READ_KEY, 8'h00, 8'h00, 8'h00);
    queue_item(OP_KEY, 8'h00, 8'h00, 8'h00);
    queue_item(OP_READ_KEY, 8'h00, 8'h00, 8'h00);
    queue_item(OP_KEY, 8'hFF, 8'hFF, 8'hFF);
    queue_item(OP_KEY, 8'h00, 8'h00, 8'h31);
    queue_item(OP_READ_KEY, 8'h00, 8'h00, 8'h00);
    queue_item(OP_READ_KEY, 8'hFF, 8'hFF, 8'hFF);
    wait_drained();

    // backspace code 0: zero and high codes both latch backspace
    write_backspace(8'h00);
    queue_item(OP_KEY, 8'h00, 8'h00, 8'h00);
    queue_item(OP_READ_KEY, 8'h00, 8'h00, 8'h00);
    queue_item(OP_KEY, 8'h00, 8'h00, 8'h9C);
    queue_item(OP_READ_KEY, 8'h00, 8'h00, 8'h00);
    queue_random(100);
    wait_drained();

    // backspace code that no filtered key can match, plus a whole-screen repaint
    write_backspace(8'hFF);
    for (int i = 0; i < VRAM_BYTES; i++)
      queue_item(OP_WRITE, 8'(i), 8'($urandom), 8'($urandom));
    queue_item(OP_END, 8'h00, 8'h00, 8'h00);
    queue_item(OP_END, 8'h00, 8'h00, 8'h00);
    queue_random(100);
    wait_drained();

    write_backspace(8'($urandom_range(0, 127)));
    calm = 1'b1;
    queue_random(50);
    wait_drained();
    calm = 1'b0;
    queue_random(50);
    wait_drained();

    repeat (10) @(posedge clk);
    if (fail_cnt == 0)
      $display("CHECK OK");
    else
      $display("CHECK FAILED");
    $finish;
  end

endmodule

>>> text_vram_dirty_tracker_with_key_latch_core.f
+incdir+hw/rtl
hw/rtl/tvdt_pkg.sv
hw/rtl/text_vram_dirty_tracker_with_key_latch_core.sv
hw/rtl/tvdt_checker.sv
dv/tb_text_vram_dirty_tracker_with_key_latch_core.sv
